/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
// Clocked on i_clk; the reset-qualified form is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* design/bpeg_pkg.sv */
// Package for the button press event generator: widths, event codes, command
// and event structs. No dependencies.
`timescale 1ns / 1ps

package bpeg_pkg;

    localparam int NUM_BUTTONS = 7;
    localparam int BTN_IDX_W   = $clog2(NUM_BUTTONS);
    localparam int CODE_W      = 16;
    localparam int DELTA_W     = 16;
    localparam int AMT_W       = 8;
    localparam int TICKS_W     = 16;
    localparam logic [TICKS_W-1:0] LONG_TICKS_RST = 16'd500;
    localparam logic signed [AMT_W-1:0] AMT_MAX = 8'sd64;
    localparam logic signed [AMT_W-1:0] AMT_MIN = -8'sd64;

    // Command queue depth; a power of two so the pointers wrap by themselves.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        KIND_DOWN         = 3'd0,
        KIND_PRESS        = 3'd1,
        KIND_LONG_PRESS   = 3'd2,
        KIND_LONG_RELEASE = 3'd3,
        KIND_ENCODER      = 3'd4
    } t_kind;

    typedef struct packed {
        logic                    is_enc;
        logic [NUM_BUTTONS-1:0]  levels;
        logic [CODE_W-1:0]       code;
        logic signed [AMT_W-1:0] amount;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        t_kind                   kind;
        logic [CODE_W-1:0]       code;
        logic signed [AMT_W-1:0] amount;
        logic [NUM_BUTTONS-1:0]  held;
        logic                    last;
    } t_event;

endpackage

/* design/bpeg_front.sv */
// Front end: takes input transfers, clamps encoder deltas and drops empty turns.
// Depends on bpeg_pkg.
`timescale 1ns / 1ps

module bpeg_front (
    input  logic                                i_req_type,
    input  logic [bpeg_pkg::NUM_BUTTONS-1:0]    i_button_levels,
    input  logic [bpeg_pkg::CODE_W-1:0]         i_encoder_control,
    input  logic signed [bpeg_pkg::DELTA_W-1:0] i_encoder_delta,
    input  logic                                i_accept,
    output bpeg_pkg::t_push                     o_push
);

    logic signed [bpeg_pkg::AMT_W-1:0] clamped;

    always_comb begin
        if (i_encoder_delta > 16'sd64) begin
            clamped = bpeg_pkg::AMT_MAX;
        end else if (i_encoder_delta < -16'sd64) begin
            clamped = bpeg_pkg::AMT_MIN;
        end else begin
            clamped = i_encoder_delta[bpeg_pkg::AMT_W-1:0];
        end
    end

    always_comb begin
        o_push.cmd.is_enc = i_req_type;
        o_push.cmd.levels = i_button_levels;
        o_push.cmd.code   = i_encoder_control;
        o_push.cmd.amount = clamped;
        // A turn of zero detents produces nothing, so it never reaches the queue.
        o_push.valid      = i_accept && !(i_req_type && (i_encoder_delta == '0));
    end

endmodule

/* design/bpeg_queue.sv */
// Short command queue between the front end and the event engine.
// Depends on bpeg_pkg.
`timescale 1ns / 1ps

module bpeg_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpeg_pkg::t_push     i_push,
    input  logic                i_pop,
    output bpeg_pkg::t_head     o_head,
    output bpeg_pkg::t_q_status o_status
);

    bpeg_pkg::t_cmd                  r_mem [bpeg_pkg::QDEPTH];
    logic [bpeg_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [bpeg_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [bpeg_pkg::QCNT_W-1:0]     r_count, n_count;
    logic                            do_push;
    logic                            do_pop;

    always_comb begin
        do_push  = i_push.valid && (r_count != bpeg_pkg::QCNT_W'(bpeg_pkg::QDEPTH));
        do_pop   = i_pop && (r_count != '0);
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_comb begin
        o_head.valid    = (r_count != '0);
        o_head.cmd      = r_mem[r_rd_ptr];
        o_status.full   = (r_count == bpeg_pkg::QCNT_W'(bpeg_pkg::QDEPTH));
        o_status.empty  = (r_count == '0);
    end

endmodule

/* design/bpeg_back.sv */
// Event engine: holds button state, turns queued commands into events and drains them one
// per cycle into the output register unless the output stalls. Depends on bpeg_pkg.
`timescale 1ns / 1ps

module bpeg_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [bpeg_pkg::TICKS_W-1:0]       i_long_ticks,
    input  bpeg_pkg::t_head                    i_head,
    output logic                               o_pop,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output bpeg_pkg::t_event                   o_event
);

    function automatic logic [bpeg_pkg::TICKS_W-1:0] sat_inc(
        input logic [bpeg_pkg::TICKS_W-1:0] v
    );
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    // Button state.
    logic [bpeg_pkg::NUM_BUTTONS-1:0] r_held;
    logic [bpeg_pkg::TICKS_W-1:0]     r_elapsed [bpeg_pkg::NUM_BUTTONS];
    logic [bpeg_pkg::TICKS_W-1:0]     n_elapsed [bpeg_pkg::NUM_BUTTONS];

    // Events of the command in progress.
    logic [bpeg_pkg::NUM_BUTTONS-1:0] r_pend, n_pend;
    logic                             r_enc_pend, n_enc_pend;
    bpeg_pkg::t_kind                  r_kinds [bpeg_pkg::NUM_BUTTONS];
    bpeg_pkg::t_kind                  ev_kind [bpeg_pkg::NUM_BUTTONS];
    logic [bpeg_pkg::NUM_BUTTONS-1:0] ev_mask;
    logic [bpeg_pkg::NUM_BUTTONS-1:0] r_lvl;
    logic [bpeg_pkg::CODE_W-1:0]      r_enc_code;
    logic signed [bpeg_pkg::AMT_W-1:0] r_enc_amt;

    // Output register.
    logic                             r_out_valid;
    bpeg_pkg::t_event                 r_out, n_out;

    logic [bpeg_pkg::NUM_BUTTONS-1:0] sel_oh;
    logic [bpeg_pkg::BTN_IDX_W-1:0]   sel_idx;
    logic                             found;
    logic                             out_free;
    logic                             emit_fire;
    logic [bpeg_pkg::NUM_BUTTONS-1:0] pend_rest;
    logic                             pop;
    logic [bpeg_pkg::NUM_BUTTONS-1:0] lv;
    logic [bpeg_pkg::TICKS_W-1:0]     inc;

    // Per-button classification against the latched state.
    always_comb begin
        lv = i_head.cmd.levels;
        for (int i = 0; i < bpeg_pkg::NUM_BUTTONS; i++) begin
            inc          = sat_inc(r_elapsed[i]);
            ev_mask[i]   = 1'b0;
            ev_kind[i]   = bpeg_pkg::KIND_DOWN;
            n_elapsed[i] = r_elapsed[i];
            if (lv[i] && !r_held[i]) begin
                ev_mask[i]   = 1'b1;
                n_elapsed[i] = '0;
            end else if (!lv[i] && r_held[i]) begin
                ev_mask[i]   = 1'b1;
                ev_kind[i]   = (inc < i_long_ticks) ? bpeg_pkg::KIND_PRESS
                                                    : bpeg_pkg::KIND_LONG_RELEASE;
                n_elapsed[i] = '0;
            end else if (lv[i]) begin
                n_elapsed[i] = inc;
                if (inc == i_long_ticks) begin
                    ev_mask[i] = 1'b1;
                    ev_kind[i] = bpeg_pkg::KIND_LONG_PRESS;
                end
            end
        end
    end

    // Lowest pending button goes out first.
    always_comb begin
        sel_oh  = '0;
        sel_idx = '0;
        found   = 1'b0;
        for (int i = 0; i < bpeg_pkg::NUM_BUTTONS; i++) begin
            if (r_pend[i] && !found) begin
                found     = 1'b1;
                sel_idx   = bpeg_pkg::BTN_IDX_W'(i);
                sel_oh[i] = 1'b1;
            end
        end
    end

    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        emit_fire = (r_enc_pend || found) && out_free;
        pend_rest = r_pend & ~sel_oh;

        n_pend     = r_pend;
        n_enc_pend = r_enc_pend;
        n_out      = r_out;
        if (emit_fire) begin
            if (r_enc_pend) begin
                n_enc_pend   = 1'b0;
                n_out.kind   = bpeg_pkg::KIND_ENCODER;
                n_out.code   = r_enc_code;
                n_out.amount = r_enc_amt;
                n_out.held   = r_lvl;
                n_out.last   = 1'b1;
            end else begin
                n_pend       = pend_rest;
                n_out.kind   = r_kinds[sel_idx];
                n_out.code   = bpeg_pkg::CODE_W'(sel_oh);
                n_out.amount = '0;
                n_out.held   = r_lvl;
                n_out.last   = (pend_rest == '0);
            end
        end
        // The next command is taken as soon as nothing is left to drain.
        pop = i_head.valid && (n_pend == '0) && !n_enc_pend;
        if (pop) begin
            if (i_head.cmd.is_enc) begin
                n_enc_pend = 1'b1;
            end else begin
                n_pend = ev_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_pend      <= '0;
            r_enc_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < bpeg_pkg::NUM_BUTTONS; i++) begin
                r_elapsed[i] <= '0;
            end
        end else begin
            r_pend     <= n_pend;
            r_enc_pend <= n_enc_pend;
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            if (pop && !i_head.cmd.is_enc) begin
                r_held <= lv;
                for (int i = 0; i < bpeg_pkg::NUM_BUTTONS; i++) begin
                    r_elapsed[i] <= n_elapsed[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (pop) begin
            r_enc_code <= i_head.cmd.code;
            r_enc_amt  <= i_head.cmd.amount;
            r_lvl      <= i_head.cmd.is_enc ? r_held : lv;
            for (int i = 0; i < bpeg_pkg::NUM_BUTTONS; i++) begin
                r_kinds[i] <= ev_kind[i];
            end
        end
    end

    assign o_pop       = pop;
    assign o_out_valid = r_out_valid;
    assign o_event     = r_out;

endmodule

/* design/button_press_event_generator.sv */
// Top level of the button press event generator: configuration register,
// front end, command queue and event engine. Depends on bpeg_pkg, bpeg_front,
// bpeg_queue, bpeg_back and assert_macros.svh.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   req_type, levels, encoder ctl/delta
//   output    out        o_out_valid / i_out_stall kind, code, amount, held mask, last
//   config    in         i_cfg_we                  i_cfg_wdata (long_press_ticks)
//
// A tick transfer yields at most seven events and an encoder transfer one; the
// engine drains one event per cycle into the output register while the output is not
// stalled, and takes the next command in the cycle of its last.
// A two-entry command queue lets the input side keep accepting while events drain.
// Reset is synchronous and active low and clears button state; the threshold
// returns to 500. An output stall holds the event; the input stalls only when
// the queue is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module button_press_event_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration.
    input  logic                                i_cfg_we,
    input  logic [bpeg_pkg::TICKS_W-1:0]        i_cfg_wdata,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic [bpeg_pkg::NUM_BUTTONS-1:0]    i_button_levels,
    input  logic [bpeg_pkg::CODE_W-1:0]         i_encoder_control,
    input  logic signed [bpeg_pkg::DELTA_W-1:0] i_encoder_delta,
    // Output channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_event_kind,
    output logic [bpeg_pkg::CODE_W-1:0]         o_control_code,
    output logic signed [bpeg_pkg::AMT_W-1:0]   o_turn_amount,
    output logic [bpeg_pkg::NUM_BUTTONS-1:0]    o_held_mask,
    output logic                                o_last
);

    // Long-press threshold. Written only while the block is idle: a user rule, unchecked.
    logic [bpeg_pkg::TICKS_W-1:0] r_long_ticks;

    bpeg_pkg::t_push     push;
    bpeg_pkg::t_head     head;
    bpeg_pkg::t_q_status q_status;
    bpeg_pkg::t_event    evt;
    logic                pop;
    logic                in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= bpeg_pkg::LONG_TICKS_RST;
        end else if (i_cfg_we) begin
            r_long_ticks <= i_cfg_wdata;
        end
    end

    // A transfer is taken whenever the queue has room.
    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    bpeg_front u_front (
        .i_req_type        (i_req_type),
        .i_button_levels   (i_button_levels),
        .i_encoder_control (i_encoder_control),
        .i_encoder_delta   (i_encoder_delta),
        .i_accept          (in_accept),
        .o_push            (push)
    );

    bpeg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    bpeg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_long_ticks (r_long_ticks),
        .i_head       (head),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_event      (evt)
    );

    assign o_event_kind   = evt.kind;
    assign o_control_code = evt.code;
    assign o_turn_amount  = evt.amount;
    assign o_held_mask    = evt.held;
    assign o_last         = evt.last;

    // An encoder event is always the only event of its transfer.
    `ASSERT_CLK(a_enc_last, (o_out_valid && (o_event_kind == bpeg_pkg::KIND_ENCODER)) |-> o_last, "encoder event without last")
    // Button events name exactly one button and carry no turn amount.
    `ASSERT_CLK(a_btn_onehot, (o_out_valid && (o_event_kind != bpeg_pkg::KIND_ENCODER)) |-> ($onehot(o_control_code) && (o_turn_amount == '0)), "malformed button event")
    // Encoder amounts stay inside the clamp range.
    `ASSERT_CLK(a_amt_range, (o_out_valid && (o_event_kind == bpeg_pkg::KIND_ENCODER)) |-> ((o_turn_amount <= bpeg_pkg::AMT_MAX) && (o_turn_amount >= bpeg_pkg::AMT_MIN) && (o_turn_amount != '0)), "encoder amount out of range")
    // Reset leaves the output empty and the input open.
    `ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_out_valid && !o_in_stall), "not idle after reset")

endmodule

/* sim/button_press_event_generator_tb.sv */
// Self-checking testbench for button_press_event_generator: directed and random button
// ticks and encoder turns, checked event by event against an in-bench prediction.
// Depends on bpeg_pkg and the design sources of the block.
`timescale 1ns / 1ps

module button_press_event_generator_tb;
    import bpeg_pkg::*;

    // Cycles to wait once nothing is expected: the queue may still hold a tick
    // that produces no event.
    localparam int SETTLE_CYCLES = 24;
    // Cycle limit after which the watchdog ends the run.
    localparam int CYCLE_LIMIT   = 100_000;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_TURN = 1'b1;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BEAT
    } t_stall_mode;

    // One input transfer as the sender sees it.
    typedef struct packed {
        logic                   req_type;
        logic [NUM_BUTTONS-1:0] levels;
        logic [CODE_W-1:0]      ctl;
        logic [DELTA_W-1:0]     delta;
    } t_req;

    // One predicted output transfer.
    typedef struct packed {
        t_kind                  kind;
        logic [CODE_W-1:0]      code;
        logic [AMT_W-1:0]       amount;
        logic [NUM_BUTTONS-1:0] held;
        logic                   last;
    } t_btn_event;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [TICKS_W-1:0]        i_cfg_wdata;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_req_type;
    logic [NUM_BUTTONS-1:0]    i_button_levels;
    logic [CODE_W-1:0]         i_encoder_control;
    logic signed [DELTA_W-1:0] i_encoder_delta;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [2:0]                o_event_kind;
    logic [CODE_W-1:0]         o_control_code;
    logic signed [AMT_W-1:0]   o_turn_amount;
    logic [NUM_BUTTONS-1:0]    o_held_mask;
    logic                      o_last;

    button_press_event_generator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_button_levels   (i_button_levels),
        .i_encoder_control (i_encoder_control),
        .i_encoder_delta   (i_encoder_delta),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_event_kind      (o_event_kind),
        .o_control_code    (o_control_code),
        .o_turn_amount     (o_turn_amount),
        .o_held_mask       (o_held_mask),
        .o_last            (o_last)
    );

    // Stimulus waiting for the driver, and events waiting for the block to emit them.
    t_req       req_backlog[$];
    t_btn_event pending_events[$];

    // The bench's own copy of the block state: threshold, latched levels, hold counters.
    logic [TICKS_W-1:0]     long_thresh;
    logic [NUM_BUTTONS-1:0] latched_levels;
    logic [TICKS_W-1:0]     hold_ticks[NUM_BUTTONS];

    // Level word of the last tick placed in the backlog, so random walks continue from it.
    logic [NUM_BUTTONS-1:0] queued_levels;

    int          err_count;
    int          cycle_count;
    logic        in_taken;
    int          gap_left;
    int          burst_left;
    t_req        drive_req;
    t_stall_mode stall_mode;
    int          stall_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [TICKS_W-1:0] sat_bump(input logic [TICKS_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic t_btn_event button_event(input t_kind kind, input int idx,
                                                input logic [NUM_BUTTONS-1:0] levels);
        t_btn_event ev;
        ev.kind   = kind;
        ev.code   = CODE_W'(1) << idx;
        ev.amount = '0;
        ev.held   = levels;
        ev.last   = 1'b0;
        return ev;
    endfunction

    // Works out the events one accepted transfer causes and advances the state copy.
    // Buttons are scanned from bit 0 up; each contributes at most one event.
    task automatic derive_events(input t_req r);
        t_btn_event         evs[NUM_BUTTONS];
        t_btn_event         ev;
        logic [TICKS_W-1:0] held_for;
        int                 d;
        int                 n;
        int                 i;
        n = 0;
        if (r.req_type == REQ_TURN) begin
            d = $signed(r.delta);
            if (d != 0) begin
                if (d > int'(AMT_MAX)) d = int'(AMT_MAX);
                if (d < int'(AMT_MIN)) d = int'(AMT_MIN);
                ev.kind   = KIND_ENCODER;
                ev.code   = r.ctl;
                ev.amount = d[AMT_W-1:0];
                // A turn reports the levels latched by the last tick, not its own field.
                ev.held   = latched_levels;
                ev.last   = 1'b1;
                pending_events.push_back(ev);
            end
        end else begin
            for (i = 0; i < NUM_BUTTONS; i++) begin
                if (r.levels[i] && !latched_levels[i]) begin
                    hold_ticks[i] = '0;
                    evs[n] = button_event(KIND_DOWN, i, r.levels);
                    n++;
                end else if (!r.levels[i] && latched_levels[i]) begin
                    // The releasing tick counts toward the hold time.
                    held_for = sat_bump(hold_ticks[i]);
                    evs[n] = button_event((held_for < long_thresh) ? KIND_PRESS
                                                                   : KIND_LONG_RELEASE,
                                          i, r.levels);
                    n++;
                    hold_ticks[i] = '0;
                end else if (r.levels[i]) begin
                    // Long press fires only on the exact tick the count meets the
                    // threshold, so a zero threshold never fires it.
                    hold_ticks[i] = sat_bump(hold_ticks[i]);
                    if (hold_ticks[i] == long_thresh) begin
                        evs[n] = button_event(KIND_LONG_PRESS, i, r.levels);
                        n++;
                    end
                end
            end
            latched_levels = r.levels;
            if (n > 0) evs[n-1].last = 1'b1;
            for (i = 0; i < n; i++) pending_events.push_back(evs[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    task automatic check_event();
        t_btn_event want;
        if (pending_events.size() == 0) begin
            flag_mismatch("event transfer with nothing pending");
            return;
        end
        want = pending_events.pop_front();
        check_field("event_kind", 16'(o_event_kind), 16'(want.kind));
        check_field("control_code", o_control_code, want.code);
        check_field("turn_amount", {8'd0, o_turn_amount}, {8'd0, want.amount});
        check_field("held_mask", 16'(o_held_mask), 16'(want.held));
        check_field("last", 16'(o_last), 16'(want.last));
    endtask

    // Monitor: samples both channels at the rising edge. Outputs are checked before
    // the new input is predicted, which keeps the pending list in emission order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) check_event();
            if (i_in_valid && !o_in_stall)
                derive_events({i_req_type, i_button_levels, i_encoder_control,
                               i_encoder_delta});
        end
    end

    // Watchdog: a missing event or a hung handshake ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("button_press_event_generator_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Sender: bursts of back-to-back transfers separated by random gaps. A payload
    // only moves on once the previous transfer went through, so a stalled item holds.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
                drive_req = req_backlog.pop_front();
                i_req_type        <= drive_req.req_type;
                i_button_levels   <= drive_req.levels;
                i_encoder_control <= drive_req.ctl;
                i_encoder_delta   <= drive_req.delta;
                i_in_valid        <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    // About a quarter of the bursts run straight into the next one.
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern switches among four modes after stretches of random length,
    // including stretches with no stall at all.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 64);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= stall_left[1];
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_tick(input logic [NUM_BUTTONS-1:0] levels);
        t_req r;
        r.req_type = REQ_TICK;
        r.levels   = levels;
        // Encoder fields are don't-care on a tick; random values show they are ignored.
        r.ctl      = CODE_W'($urandom);
        r.delta    = DELTA_W'($urandom);
        req_backlog.push_back(r);
        queued_levels = levels;
    endtask

    task automatic push_turn(input logic [CODE_W-1:0] ctl, input logic [DELTA_W-1:0] delta);
        t_req r;
        r.req_type = REQ_TURN;
        // Levels on a turn are ignored by the block.
        r.levels   = NUM_BUTTONS'($urandom);
        r.ctl      = ctl;
        r.delta    = delta;
        req_backlog.push_back(r);
    endtask

    function automatic logic [DELTA_W-1:0] random_delta();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return DELTA_W'($urandom_range(0, 160) - 80);
            2:       return ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
            default: return DELTA_W'($urandom);
        endcase
    endfunction

    // Mostly a random walk of the level word, so buttons stay held for stretches around
    // the threshold; the rest is encoder turns and the odd fully random level word.
    task automatic queue_random_mix(input int count, input int flip_div);
        logic [NUM_BUTTONS-1:0] lv;
        int                     i;
        int                     b;
        for (i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0, 1: push_turn(CODE_W'($urandom), random_delta());
                2:    push_tick(NUM_BUTTONS'($urandom));
                default: begin
                    lv = queued_levels;
                    for (b = 0; b < NUM_BUTTONS; b++)
                        if ($urandom_range(0, flip_div - 1) == 0) lv[b] = ~lv[b];
                    push_tick(lv);
                end
            endcase
        end
    endtask

    // Waits until every queued transfer went in and every expected event came out,
    // then lets the pipeline empty of ticks that produce nothing.
    task automatic settle();
        while (req_backlog.size() != 0 || i_in_valid || pending_events.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Only called while the block is idle; the copy tracks the edge of the write.
    task automatic set_threshold(input logic [TICKS_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        long_thresh = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int lo[4];
        int hi[4];
        int p;
        int thr;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        i_in_valid        = 1'b0;
        i_out_stall       = 1'b0;
        i_req_type        = REQ_TICK;
        i_button_levels   = '0;
        i_encoder_control = '0;
        i_encoder_delta   = '0;
        err_count         = 0;
        cycle_count       = 0;
        gap_left          = 0;
        burst_left        = 0;
        stall_left        = 0;
        stall_mode        = STALL_NONE;
        long_thresh       = LONG_TICKS_RST;
        latched_levels    = '0;
        queued_levels     = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) hold_ticks[i] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset threshold. Turns come first, so they report an
        // all-zero held mask; a zero delta must produce nothing.
        push_turn(16'h0000, 16'sd0);
        push_turn(16'h5A5A, 16'sd64);
        push_turn(16'hA5A5, 16'sd65);
        push_turn(16'h1234, -16'sd64);
        push_turn(16'hFEDC, -16'sd65);
        push_turn(16'hFFFF, 16'sh7FFF);
        push_turn(16'h7FFF, 16'sh8000);
        push_tick(7'h00);
        // All seven buttons down in one tick: the longest event train, then a quiet hold.
        push_tick(7'h7F);
        push_tick(7'h7F);
        push_turn(16'h0001, 16'sd3);
        // All released well below 500 ticks: seven short presses.
        push_tick(7'h00);
        push_tick(7'h55);
        push_tick(7'h2A);
        push_tick(7'h00);
        settle();

        // Threshold of one: long press on the first held tick, every release is long.
        set_threshold(16'd1);
        push_tick(7'h01);
        push_tick(7'h01);
        push_tick(7'h00);
        settle();

        // Zero threshold: long press never fires and every release is long.
        set_threshold(16'd0);
        push_tick(7'h03);
        push_tick(7'h03);
        push_tick(7'h00);
        settle();

        // Threshold of two: a one-tick tap is short, a longer hold fires long press
        // and then releases long.
        set_threshold(16'd2);
        push_tick(7'h01);
        push_tick(7'h00);
        push_tick(7'h01);
        push_tick(7'h01);
        push_tick(7'h01);
        push_tick(7'h00);
        settle();

        // Random part over several small thresholds, where long events are frequent.
        lo = '{1, 2, 4, 1};
        hi = '{3, 6, 12, 20};
        for (p = 0; p < 4; p++) begin
            thr = $urandom_range(lo[p], hi[p]);
            set_threshold(TICKS_W'(thr));
            queue_random_mix(20, thr + 2);
            settle();
        end

        if (err_count == 0) begin
            $display("button_press_event_generator_tb: clean");
        end else begin
            $display("button_press_event_generator_tb: errors");
        end
        $finish;
    end

endmodule
